// ----- design/rigid_warp_bilinear_sq_error_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the rigid warp squared error block
// Concurrent checks clocked on clock; ASSERT_OFF compiles them out.
// ----------------------------------------------------------------------------
`ifndef RIGID_WARP_BILINEAR_SQ_ERROR_ASSERT_SVH
`define RIGID_WARP_BILINEAR_SQ_ERROR_ASSERT_SVH
`ifndef ASSERT_OFF
`define RWB_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define RWB_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define RWB_ASSERT(lbl, prop, msg)
`define RWB_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ----- design/rwb_pkg.sv -----
// ----------------------------------------------------------------------------
// rwb_pkg
// Types and constants shared by the rigid warp squared error block.
// ----------------------------------------------------------------------------
package rwb_pkg;

   localparam int MaxRowPixelsDefault = 256;
   localparam int MaxRowsDefault      = 256;
   localparam int CsrAddrWidth        = 5;

   localparam logic KindLoad = 1'b0;
   localparam logic KindTest = 1'b1;

   typedef enum logic [2:0] {
      REG_ROTATION_COS = 3'd0,
      REG_ROTATION_SIN = 3'd1,
      REG_SHIFT_X      = 3'd2,
      REG_SHIFT_Y      = 3'd3,
      REG_THRESHOLD_SQ = 3'd4,
      REG_RECT_LOW     = 3'd5,
      REG_RECT_HIGH    = 3'd6,
      REG_ROW_SIZE     = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic signed [15:0] rotation_cos;
      logic signed [15:0] rotation_sin;
      logic signed [16:0] shift_x;
      logic signed [16:0] shift_y;
      logic        [31:0] threshold_sq;
      logic        [15:0] rect_low;
      logic        [15:0] rect_high;
      logic        [8:0]  row_size;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic push;
   } core_status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL, S_SUM, S_CHK, S_MOD, S_RD0, S_RD1, S_RD2,
      S_RD3, S_GET, S_HOR, S_VER, S_DIF, S_SQR, S_ACC, S_FIN
   } core_state_type;

endpackage

// ----- design/rwb_if.sv -----
// ----------------------------------------------------------------------------
// rwb request and response channels
// Valid/ready channels carrying pixel requests and error sum results.
// ----------------------------------------------------------------------------
interface rwb_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] pixel_value;
   logic       last;

   modport source(output valid, kind, pixel_value, last, input ready);
   modport sink(input valid, kind, pixel_value, last, output ready);
endinterface

interface rwb_rsp_if;
   logic        valid;
   logic        ready;
   logic [47:0] error_sum;
   logic        overflow;

   modport source(output valid, error_sum, overflow, input ready);
   modport sink(input valid, error_sum, overflow, output ready);
endinterface

// ----- design/rwb_ram.sv -----
// ----------------------------------------------------------------------------
// rwb_ram
// Single port synchronous RAM, one access per cycle, registered read.
// ----------------------------------------------------------------------------
module rwb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- design/rwb_csr.sv -----
// ----------------------------------------------------------------------------
// rwb_csr
// APB register file holding the warp, threshold, rectangle and row size.
// ----------------------------------------------------------------------------
module rwb_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [rwb_pkg::CsrAddrWidth-1:0]  paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready,
   output rwb_pkg::cfg_type                  cfg
);
   import rwb_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type idx;
   logic          wr;

   assign idx    = reg_index_type'(paddr[CsrAddrWidth-1:2]);
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            REG_ROTATION_COS: cfg_in.rotation_cos = pwdata[15:0];
            REG_ROTATION_SIN: cfg_in.rotation_sin = pwdata[15:0];
            REG_SHIFT_X:      cfg_in.shift_x      = pwdata[16:0];
            REG_SHIFT_Y:      cfg_in.shift_y      = pwdata[16:0];
            REG_THRESHOLD_SQ: cfg_in.threshold_sq = pwdata;
            REG_RECT_LOW:     cfg_in.rect_low     = pwdata[15:0];
            REG_RECT_HIGH:    cfg_in.rect_high    = pwdata[15:0];
            REG_ROW_SIZE:     cfg_in.row_size     = pwdata[8:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_ROTATION_COS: prdata = 32'(cfg_ff.rotation_cos);
         REG_ROTATION_SIN: prdata = 32'(cfg_ff.rotation_sin);
         REG_SHIFT_X:      prdata = 32'(cfg_ff.shift_x);
         REG_SHIFT_Y:      prdata = 32'(cfg_ff.shift_y);
         REG_THRESHOLD_SQ: prdata = cfg_ff.threshold_sq;
         REG_RECT_LOW:     prdata = {16'd0, cfg_ff.rect_low};
         REG_RECT_HIGH:    prdata = {16'd0, cfg_ff.rect_high};
         REG_ROW_SIZE:     prdata = {23'd0, cfg_ff.row_size};
         default:          prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rotation_cos <= 16'sd16384;
         cfg_ff.rotation_sin <= '0;
         cfg_ff.shift_x      <= '0;
         cfg_ff.shift_y      <= '0;
         cfg_ff.threshold_sq <= '1;
         cfg_ff.rect_low     <= '0;
         cfg_ff.rect_high    <= '1;
         cfg_ff.row_size     <= 9'd256;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

// ----- design/rwb_core.sv -----
// ----------------------------------------------------------------------------
// rwb_core
// Pixel store sequencer: loads reference pixels, warps test positions,
// reads four neighbors, interpolates and accumulates the squared error.
// ----------------------------------------------------------------------------
module rwb_core #(
   parameter int MAX_ROW_PIXELS = rwb_pkg::MaxRowPixelsDefault,
   parameter int MAX_ROWS       = rwb_pkg::MaxRowsDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rwb_pkg::cfg_type        cfg,
   input  logic                    req_valid,
   input  logic                    req_kind,
   input  logic [7:0]              req_pixel_value,
   input  logic                    req_last,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [47:0]             rsp_error_sum,
   output logic                    rsp_overflow,
   output rwb_pkg::core_status_type status
);
   import rwb_pkg::*;

   localparam int StoreDepth = MAX_ROW_PIXELS * MAX_ROWS;
   localparam int AW   = $clog2(StoreDepth);
   localparam int CW   = $clog2(MAX_ROW_PIXELS);
   localparam int RW   = $clog2(MAX_ROWS);
   localparam int RSW  = $clog2(MAX_ROW_PIXELS + 1);
   localparam int BW   = 9 + RSW;
   localparam int WW   = (BW > AW) ? BW : AW;
   localparam int KTOP = WW - AW;
   localparam int KW   = (KTOP > 0) ? $clog2(KTOP + 1) : 1;

   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                              input logic [AW:0] b);
      logic [AW:0] s;
      s = {1'b0, a} + b;
      if (s >= (AW+1)'(StoreDepth)) begin
         s = s - (AW+1)'(StoreDepth);
      end
      return s[AW-1:0];
   endfunction

   core_state_type     state_ff, state_in;
   logic [AW-1:0]      load_addr_ff, load_addr_in;
   logic [CW-1:0]      col_ff, col_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [47:0]        total_ff, total_in;
   logic               sat_ff, sat_in;
   logic [7:0]         pix_ff, pix_in;
   logic               last_ff, last_in;
   logic signed [31:0] pcx_ff, pcx_in, psy_ff, psy_in, psx_ff, psx_in, pcy_ff, pcy_in;
   logic signed [31:0] xq_ff, xq_in, yq_ff, yq_in;
   logic [WW-1:0]      rem_ff, rem_in;
   logic [KW-1:0]      k_ff, k_in;
   logic [AW-1:0]      a0_ff, a0_in, a2_ff, a2_in;
   logic [7:0]         p_ff [4];
   logic [7:0]         p_in [4];
   logic [21:0]        top_ff, top_in, bot_ff, bot_in;
   logic [35:0]        t_ff, t_in;
   logic signed [17:0] d_ff, d_in;
   logic [31:0]        sq_ff, sq_in;
   logic               out_valid_ff, out_valid_in;
   logic [47:0]        out_sum_ff, out_sum_in;
   logic               out_ovf_ff, out_ovf_in;

   logic [RSW-1:0]     rs_eff;
   logic [RSW-1:0]     col_p1;
   logic signed [17:0] xm, ym;
   logic [7:0]         ux, uy;
   logic               in_rect;
   logic [WW-1:0]      dsh;
   logic [14:0]        wx1, wx0, wy1, wy0;
   logic [15:0]        v8;
   logic [35:0]        t_rnd;
   logic signed [35:0] sq_full;
   logic [48:0]        sum49;
   logic               push;
   logic               ram_we;
   logic [AW-1:0]      ram_addr;
   logic [7:0]         ram_wdata, ram_rdata;

   rwb_ram #(.WIDTH(8), .DEPTH(StoreDepth)) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // Row size 0 acts as 1, oversize clamps to the row capacity.
   always_comb begin
      if (cfg.row_size == 9'd0) begin
         rs_eff = RSW'(1);
      end else if (32'(cfg.row_size) > MAX_ROW_PIXELS) begin
         rs_eff = RSW'(MAX_ROW_PIXELS);
      end else begin
         rs_eff = RSW'(cfg.row_size);
      end
   end

   assign col_p1 = RSW'(col_ff) + RSW'(1);
   assign xm     = xq_ff[31:14];
   assign ym     = yq_ff[31:14];
   assign ux     = xq_ff[21:14];
   assign uy     = yq_ff[21:14];
   assign in_rect = (xm >= $signed({10'd0, cfg.rect_low[7:0]}))
                 && (ym >= $signed({10'd0, cfg.rect_low[15:8]}))
                 && ((xm + 18'sd1) <= $signed({10'd0, cfg.rect_high[7:0]}))
                 && ((ym + 18'sd1) <= $signed({10'd0, cfg.rect_high[15:8]}));
   assign dsh    = WW'(StoreDepth) << k_ff;
   assign wx1    = {1'b0, xq_ff[13:0]};
   assign wx0    = 15'd16384 - wx1;
   assign wy1    = {1'b0, yq_ff[13:0]};
   assign wy0    = 15'd16384 - wy1;
   assign t_rnd  = t_ff + 36'd524288;
   assign v8     = t_rnd[35:20];
   assign sq_full = d_ff * d_ff;
   assign sum49  = {1'b0, total_ff} + 49'(sq_ff);

   always_comb begin
      state_in     = state_ff;
      load_addr_in = load_addr_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      total_in     = total_ff;
      sat_in       = sat_ff;
      pix_in       = pix_ff;
      last_in      = last_ff;
      pcx_in       = pcx_ff;
      psy_in       = psy_ff;
      psx_in       = psx_ff;
      pcy_in       = pcy_ff;
      xq_in        = xq_ff;
      yq_in        = yq_ff;
      rem_in       = rem_ff;
      k_in         = k_ff;
      a0_in        = a0_ff;
      a2_in        = a2_ff;
      p_in         = p_ff;
      top_in       = top_ff;
      bot_in       = bot_ff;
      t_in         = t_ff;
      d_in         = d_ff;
      sq_in        = sq_ff;
      req_ready    = 1'b0;
      push         = 1'b0;
      ram_we       = 1'b0;
      ram_addr     = load_addr_ff;
      ram_wdata    = req_pixel_value;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_kind == KindLoad) begin
                  ram_we       = 1'b1;
                  load_addr_in = req_last ? '0 : wrap_add(load_addr_ff, (AW+1)'(1));
               end else begin
                  pix_in   = req_pixel_value;
                  last_in  = req_last;
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            pcx_in   = 32'(cfg.rotation_cos * $signed({1'b0, col_ff}));
            psy_in   = 32'(cfg.rotation_sin * $signed({1'b0, row_ff}));
            psx_in   = 32'(cfg.rotation_sin * $signed({1'b0, col_ff}));
            pcy_in   = 32'(cfg.rotation_cos * $signed({1'b0, row_ff}));
            state_in = S_SUM;
         end
         S_SUM: begin
            xq_in    = pcx_ff - psy_ff + (32'(cfg.shift_x) <<< 6);
            yq_in    = psx_ff + pcy_ff + (32'(cfg.shift_y) <<< 6);
            state_in = S_CHK;
         end
         S_CHK: begin
            rem_in   = WW'(WW'(uy) * WW'(rs_eff) + WW'(ux));
            k_in     = KW'(KTOP);
            state_in = in_rect ? S_MOD : S_FIN;
         end
         // restoring reduction of the row-major address modulo the store depth
         S_MOD: begin
            if (rem_ff >= dsh) begin
               rem_in = rem_ff - dsh;
            end
            if (k_ff == '0) begin
               state_in = S_RD0;
            end else begin
               k_in = k_ff - KW'(1);
            end
         end
         S_RD0: begin
            ram_addr = rem_ff[AW-1:0];
            a0_in    = rem_ff[AW-1:0];
            state_in = S_RD1;
         end
         S_RD1: begin
            ram_addr = wrap_add(a0_ff, (AW+1)'(1));
            a2_in    = wrap_add(a0_ff, (AW+1)'(rs_eff));
            p_in[0]  = ram_rdata;
            state_in = S_RD2;
         end
         S_RD2: begin
            ram_addr = a2_ff;
            p_in[1]  = ram_rdata;
            state_in = S_RD3;
         end
         S_RD3: begin
            ram_addr = wrap_add(a2_ff, (AW+1)'(1));
            p_in[2]  = ram_rdata;
            state_in = S_GET;
         end
         S_GET: begin
            p_in[3]  = ram_rdata;
            state_in = S_HOR;
         end
         S_HOR: begin
            top_in   = 22'(p_ff[0] * wx0 + p_ff[1] * wx1);
            bot_in   = 22'(p_ff[2] * wx0 + p_ff[3] * wx1);
            state_in = S_VER;
         end
         S_VER: begin
            t_in     = 36'(top_ff * wy0 + bot_ff * wy1);
            state_in = S_DIF;
         end
         S_DIF: begin
            d_in     = $signed({2'b0, v8}) - $signed({2'b0, pix_ff, 8'd0});
            state_in = S_SQR;
         end
         S_SQR: begin
            sq_in    = sq_full[31:0];
            state_in = S_ACC;
         end
         S_ACC: begin
            if (sq_ff <= cfg.threshold_sq) begin
               if (sum49[48]) begin
                  total_in = '1;
                  sat_in   = 1'b1;
               end else begin
                  total_in = sum49[47:0];
               end
            end
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!last_ff) begin
               if (col_p1 >= rs_eff) begin
                  col_in = '0;
                  row_in = (row_ff == RW'(MAX_ROWS - 1)) ? '0 : row_ff + RW'(1);
               end else begin
                  col_in = col_p1[CW-1:0];
               end
               state_in = S_IDLE;
            end else if (!out_valid_ff || rsp_ready) begin
               push     = 1'b1;
               total_in = '0;
               sat_in   = 1'b0;
               col_in   = '0;
               row_in   = '0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      out_sum_in   = out_sum_ff;
      out_ovf_in   = out_ovf_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      if (push) begin
         out_valid_in = 1'b1;
         out_sum_in   = total_ff;
         out_ovf_in   = sat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         load_addr_ff <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         total_ff     <= '0;
         sat_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_addr_ff <= load_addr_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         total_ff     <= total_in;
         sat_ff       <= sat_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff     <= pix_in;
      last_ff    <= last_in;
      pcx_ff     <= pcx_in;
      psy_ff     <= psy_in;
      psx_ff     <= psx_in;
      pcy_ff     <= pcy_in;
      xq_ff      <= xq_in;
      yq_ff      <= yq_in;
      rem_ff     <= rem_in;
      k_ff       <= k_in;
      a0_ff      <= a0_in;
      a2_ff      <= a2_in;
      p_ff       <= p_in;
      top_ff     <= top_in;
      bot_ff     <= bot_in;
      t_ff       <= t_in;
      d_ff       <= d_in;
      sq_ff      <= sq_in;
      out_sum_ff <= out_sum_in;
      out_ovf_ff <= out_ovf_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_error_sum = out_sum_ff;
   assign rsp_overflow  = out_ovf_ff;
   assign status.busy   = (state_ff != S_IDLE);
   assign status.push   = push;
endmodule

// ----- design/rigid_warp_bilinear_sq_error.sv -----
// Reference load request: one write to the single-port pixel store.
// Test request: S_MUL, S_SUM, S_CHK; outside the rectangle it then goes to
// S_FIN; inside, the modulo unit and four store reads come before it.
// Last test request: sum registered once the output is free, held until taken.
// Synchronous reset clears control and scan state; pixel store is not cleared.
// ----------------------------------------------------------------------------
// rigid_warp_bilinear_sq_error
// Rotated and shifted bilinear compare of a test image against a stored
// reference, accumulating a saturating sum of squared differences.
// ----------------------------------------------------------------------------
`include "rigid_warp_bilinear_sq_error_assert.svh"

module rigid_warp_bilinear_sq_error #(
   parameter int MAX_ROW_PIXELS = rwb_pkg::MaxRowPixelsDefault,
   parameter int MAX_ROWS       = rwb_pkg::MaxRowsDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   rwb_req_if.sink                          req_chan,
   rwb_rsp_if.source                        rsp_chan,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [rwb_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   import rwb_pkg::*;

   cfg_type         cfg;
   core_status_type stat;

   rwb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   rwb_core #(
      .MAX_ROW_PIXELS (MAX_ROW_PIXELS),
      .MAX_ROWS       (MAX_ROWS)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_chan.valid),
      .req_kind        (req_chan.kind),
      .req_pixel_value (req_chan.pixel_value),
      .req_last        (req_chan.last),
      .req_ready       (req_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_error_sum   (rsp_chan.error_sum),
      .rsp_overflow    (rsp_chan.overflow),
      .status          (stat)
   );

   `RWB_ASSERT_RST(a_rsp_clear_on_reset, reset |=> !rsp_chan.valid, "response valid after reset")
   `RWB_ASSERT(a_rsp_from_push, $rose(rsp_chan.valid) |-> $past(stat.push), "response without push")
   `RWB_ASSERT(a_req_only_idle, (req_chan.valid && req_chan.ready) |-> !stat.busy, "request taken while busy")
endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the rigid warp squared error block: reference loads, warped test
// passes and the saturating error sum are compared against a local predictor.
// ----------------------------------------------------------------------------
module testbench;
   import rwb_pkg::*;

   localparam int StoreDepth = 65536;
   localparam int LoadCount = 512;
   localparam int DrainCycles = 64;
   localparam int WatchdogLimit = 5000;
   localparam longint SumMax = 48'hFFFF_FFFF_FFFF;

   typedef struct {
      logic [47:0] error_sum;
      logic        overflow;
   } sum_type;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CsrAddrWidth-1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   rwb_req_if req_if();
   rwb_rsp_if rsp_if();

   rigid_warp_bilinear_sq_error u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor state
   cfg_type     warp_cfg;
   logic [7:0]  ref_image [0:StoreDepth-1];
   int          load_addr;
   int          scan_col;
   int          scan_row;
   longint      sum_acc;
   logic        sum_sat;
   sum_type     expected_sums[$];

   int          error_count;
   bit          idle_on;
   int          stall_left;
   int          rsp_hold;
   int          quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void apply_cfg(reg_index_type idx, logic [31:0] val);
      case (idx)
         REG_ROTATION_COS: warp_cfg.rotation_cos = val[15:0];
         REG_ROTATION_SIN: warp_cfg.rotation_sin = val[15:0];
         REG_SHIFT_X:      warp_cfg.shift_x = val[16:0];
         REG_SHIFT_Y:      warp_cfg.shift_y = val[16:0];
         REG_THRESHOLD_SQ: warp_cfg.threshold_sq = val;
         REG_RECT_LOW:     warp_cfg.rect_low = val[15:0];
         REG_RECT_HIGH:    warp_cfg.rect_high = val[15:0];
         default:          warp_cfg.row_size = val[8:0];
      endcase
   endfunction

   // shrink the rectangle rows so every neighbor read stays in the loaded area
   function automatic logic [15:0] fit_rect(logic [15:0] hi, logic [8:0] rs);
      int rse, xmax, ymax;
      rse = (rs == 9'd0) ? 1 : ((rs > 9'd256) ? 256 : int'(rs));
      xmax = int'(hi[7:0]);
      ymax = int'(hi[15:8]);
      if (ymax * rse + xmax > LoadCount - 1)
         ymax = (LoadCount - 1 - xmax) / rse;
      return {8'(ymax), 8'(xmax)};
   endfunction

   function automatic void predict_test_pixel(logic [7:0] pix);
      longint c, s, xq, yq, xm, ym, fx, fy, top, bot, t, v8, d, sq;
      int rs;
      c = longint'($signed(warp_cfg.rotation_cos));
      s = longint'($signed(warp_cfg.rotation_sin));
      rs = int'(warp_cfg.row_size);
      if (rs == 0) rs = 1;
      if (rs > 256) rs = 256;
      xq = c * scan_col - s * scan_row + longint'($signed(warp_cfg.shift_x)) * 64;
      yq = s * scan_col + c * scan_row + longint'($signed(warp_cfg.shift_y)) * 64;
      xm = xq >>> 14;
      ym = yq >>> 14;
      fx = xq & 16383;
      fy = yq & 16383;
      if (xm >= longint'(warp_cfg.rect_low[7:0]) && ym >= longint'(warp_cfg.rect_low[15:8]) &&
          xm + 1 <= longint'(warp_cfg.rect_high[7:0]) &&
          ym + 1 <= longint'(warp_cfg.rect_high[15:8])) begin
         top = ref_image[(ym * rs + xm) % StoreDepth] * (16384 - fx)
             + ref_image[(ym * rs + xm + 1) % StoreDepth] * fx;
         bot = ref_image[((ym + 1) * rs + xm) % StoreDepth] * (16384 - fx)
             + ref_image[((ym + 1) * rs + xm + 1) % StoreDepth] * fx;
         t = top * (16384 - fy) + bot * fy;
         v8 = (t + (longint'(1) << 19)) >> 20;
         d = v8 - longint'(pix) * 256;
         sq = d * d;
         if (sq <= longint'(warp_cfg.threshold_sq)) begin
            sum_acc += sq;
            if (sum_acc > SumMax) begin
               sum_acc = SumMax;
               sum_sat = 1'b1;
            end
         end
      end
      scan_col++;
      if (scan_col >= rs) begin
         scan_col = 0;
         scan_row = (scan_row + 1) % 256;
      end
   endfunction

   function automatic void predict_request(logic kind, logic [7:0] pix, logic last);
      sum_type r;
      if (kind == KindLoad) begin
         ref_image[load_addr] = pix;
         load_addr = last ? 0 : (load_addr + 1) % StoreDepth;
      end else begin
         predict_test_pixel(pix);
         if (last) begin
            r.error_sum = sum_acc[47:0];
            r.overflow = sum_sat;
            expected_sums.push_back(r);
            sum_acc = 0;
            sum_sat = 1'b0;
            scan_col = 0;
            scan_row = 0;
         end
      end
   endfunction

   task automatic send_pixel(logic kind, logic [7:0] pix, logic last);
      int gap;
      gap = idle_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.kind <= kind;
      req_if.pixel_value <= pix;
      req_if.last <= last;
      do @(posedge clock); while (!req_if.ready);
      predict_request(kind, pix, last);
   endtask

   task automatic stop_sending();
      req_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   // no result pending, then let the last test request finish in the core
   task automatic wait_drained();
      while (expected_sums.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [31:0] val);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      apply_cfg(idx, val);
      @(posedge clock);
   endtask

   task automatic write_warp(int cs, int sn, int sx, int sy, logic [31:0] thr,
                             logic [15:0] lo, logic [15:0] hi, logic [8:0] rs);
      write_reg(REG_ROTATION_COS, cs);
      write_reg(REG_ROTATION_SIN, sn);
      write_reg(REG_SHIFT_X, sx);
      write_reg(REG_SHIFT_Y, sy);
      write_reg(REG_THRESHOLD_SQ, thr);
      write_reg(REG_RECT_LOW, lo);
      write_reg(REG_RECT_HIGH, fit_rect(hi, rs));
      write_reg(REG_ROW_SIZE, rs);
   endtask

   task automatic test_pass(int n);
      for (int i = 0; i < n; i++)
         send_pixel(KindTest, $urandom_range(0, 255), i == n - 1);
   endtask

   // fill the low part of the store; every rectangle is kept inside it
   task automatic test_full_load();
      idle_on = 1'b0;
      for (int i = 0; i < LoadCount; i++)
         send_pixel(KindLoad, $urandom_range(0, 255), i == LoadCount - 1);
      stop_sending();
   endtask

   task automatic test_directed();
      idle_on = 1'b1;
      // identity warp, rectangle cut to the loaded rows, pixel extremes
      write_warp(16384, 0, 0, 0, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF, 9'd256);
      send_pixel(KindTest, 8'd0, 1'b0);
      send_pixel(KindTest, 8'd255, 1'b0);
      send_pixel(KindTest, 8'd170, 1'b1);
      // short load, last restarts at address zero
      send_pixel(KindLoad, 8'd255, 1'b0);
      send_pixel(KindLoad, 8'd0, 1'b1);
      send_pixel(KindLoad, 8'd85, 1'b0);
      stop_sending();
      wait_drained();
      // threshold zero, extreme rotation and shifts
      write_warp(-16384, 16384, 65535, -65536, 0, 16'h0000, 16'hFFFF, 9'd256);
      test_pass(3);
      stop_sending();
      wait_drained();
      // rectangle misses everything, row size zero
      write_warp(16384, -16384, -65536, 65535, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 9'd0);
      test_pass(3);
      stop_sending();
      wait_drained();
      // oversized row size, clamped to the row capacity
      write_warp(16384, 0, 32767, 128, 32'h8000_0000, 16'h0000, 16'hFFFF, 9'd511);
      test_pass(4);
      stop_sending();
      wait_drained();
      write_warp(11585, 11585, 300, -200, 32'hFFFF_FFFF, 16'h0100, 16'hF0FE, 9'd1);
      test_pass(5);
      stop_sending();
      wait_drained();
   endtask

   task automatic random_warp();
      int cs, sn, sx, sy;
      logic [31:0] thr;
      logic [15:0] lo, hi;
      logic [8:0] rs;
      cs = $urandom_range(0, 3) == 0 ? 16384 : $urandom_range(0, 32768) - 16384;
      sn = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 32768) - 16384;
      if ($urandom_range(0, 4) == 0) begin
         sx = $urandom_range(0, 131071) - 65536;
         sy = $urandom_range(0, 131071) - 65536;
      end else begin
         sx = $urandom_range(0, 4095);
         sy = $urandom_range(0, 4095);
      end
      case ($urandom_range(0, 3))
         0: thr = 32'hFFFF_FFFF;
         1: thr = $urandom_range(0, 32'h0100_0000);
         default: thr = $urandom;
      endcase
      lo = $urandom_range(0, 2) == 0 ? 16'h0000 : {8'($urandom_range(0, 8)), 8'($urandom_range(0, 8))};
      hi = $urandom_range(0, 2) == 0 ? 16'hFFFF : 16'($urandom_range(0, 65535));
      case ($urandom_range(0, 9))
         0: rs = 9'd0;
         1: rs = 9'd256;
         2: rs = $urandom_range(257, 511);
         default: rs = $urandom_range(1, 40);
      endcase
      write_warp(cs, sn, sx, sy, thr, lo, hi, rs);
   endtask

   task automatic test_random();
      int n;
      for (int p = 0; p < 29; p++) begin
         idle_on = $urandom_range(0, 3) != 0;
         if (p % 4 == 0) random_warp();
         // a few reference loads, sometimes ending a load pass
         n = $urandom_range(0, 4);
         for (int i = 0; i < n; i++)
            send_pixel(KindLoad, $urandom_range(0, 255), $urandom_range(0, 5) == 0);
         test_pass($urandom_range(1, 50));
         if (p % 4 == 3) begin
            stop_sending();
            wait_drained();
         end
      end
      stop_sending();
      wait_drained();
   endtask

   // receiver holds off while passes keep coming, so the input backs up
   task automatic test_backpressure();
      idle_on = 1'b0;
      stall_left = 400;
      for (int p = 0; p < 4; p++) test_pass($urandom_range(2, 6));
      stop_sending();
      wait_drained();
   endtask

   // result checker and receiver idling
   always @(posedge clock) begin
      sum_type e;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_sums.size() == 0) begin
               $display("%0t: unexpected result sum=%h ovf=%b", $time,
                        rsp_if.error_sum, rsp_if.overflow);
               error_count++;
            end else begin
               e = expected_sums.pop_front();
               if (rsp_if.error_sum !== e.error_sum) begin
                  $display("%0t: error_sum expected %h actual %h", $time,
                           e.error_sum, rsp_if.error_sum);
                  error_count++;
               end
               if (rsp_if.overflow !== e.overflow) begin
                  $display("%0t: overflow expected %b actual %b", $time,
                           e.overflow, rsp_if.overflow);
                  error_count++;
               end
            end
            rsp_hold = idle_on ? $urandom_range(0, 7) : 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles == WatchdogLimit) begin
         $display("testbench: errors");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.kind = KindLoad;
      req_if.pixel_value = 8'd0;
      req_if.last = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      warp_cfg = '{16384, 0, 0, 0, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF, 9'd256};
      foreach (ref_image[i]) ref_image[i] = 8'd0;
      load_addr = 0;
      scan_col = 0;
      scan_row = 0;
      sum_acc = 0;
      sum_sat = 1'b0;
      error_count = 0;
      idle_on = 1'b0;
      stall_left = 0;
      quiet_cycles = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_full_load();
      test_directed();
      test_backpressure();
      test_random();
      wait_drained();
      if (error_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule

// ----- rigid_warp_bilinear_sq_error.f -----
+incdir+design
design/rwb_pkg.sv
design/rwb_if.sv
design/rwb_ram.sv
design/rwb_csr.sv
design/rwb_core.sv
design/rigid_warp_bilinear_sq_error.sv
verif/testbench.sv
